// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)

`define ASSERT_CLK_NR(label, clk, prop, msg)

`endif

`endif

// File: hdl/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg
// Shared constants, types and the hex digit decode for the URL decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package upd_pkg;

    localparam logic [7:0] C_PCT   = 8'h25;
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam int         C_MAX_RES = 3;
    localparam int         C_CNT_W   = $clog2(C_MAX_RES + 1);

    typedef struct packed {
        logic [C_MAX_RES-1:0][7:0] data;
        logic [C_CNT_W-1:0]        cnt;
        logic                      last;
    } t_res_set;

    // bit 4 set when the byte is a hex digit, bits 3:0 its value
    function automatic logic [4:0] hex_nib(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/upd_in_if.sv
// ----------------------------------------------------------------------------
// upd_in_if
// Encoded byte stream channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface upd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// File: hdl/upd_out_if.sv
// ----------------------------------------------------------------------------
// upd_out_if
// Decoded byte stream channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface upd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;

    modport source (output valid, output out_byte, output run_last, output string_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input string_end,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/upd_decode.sv
// ----------------------------------------------------------------------------
// upd_decode
// Input register, escape tracking and per-beat decode into a result set.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    upd_in_if.sink            i_in,
    input  logic              i_free,
    output logic              o_res_vld,
    output upd_pkg::t_res_set o_res
);
    import upd_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_PCT  = 3'b010,
        PH_HEX  = 3'b100
    } t_phase;

    logic       r_plus_to_space;
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    t_phase     r_phase;
    t_phase     n_phase;
    logic [7:0] r_first;
    logic [7:0] n_first;
    logic [4:0] hi;
    logic [4:0] lo;
    logic       advance;
    t_res_set   res;

    assign advance    = r_in_vld && i_free;
    assign i_in.ready = !r_in_vld || i_free;
    assign o_res_vld  = r_in_vld;
    assign o_res      = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plus_to_space <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_plus_to_space <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.in_byte;
            r_in_last <= i_in.in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_first <= 8'h00;
        end else if (advance) begin
            r_phase <= n_phase;
            r_first <= n_first;
        end
    end

    always_comb begin
        hi      = hex_nib(r_first);
        lo      = hex_nib(r_in_byte);
        res     = '0;
        n_phase = r_phase;
        n_first = r_first;
        unique case (r_phase)
            PH_PCT: begin
                n_first = r_in_byte;
                if (r_in_last) begin
                    res.data[0] = C_PCT;
                    res.data[1] = r_in_byte;
                    res.cnt     = C_CNT_W'(2);
                    n_phase     = PH_IDLE;
                end else begin
                    n_phase     = PH_HEX;
                end
            end
            PH_HEX: begin
                if (hi[4] && lo[4]) begin
                    res.data[0] = {hi[3:0], lo[3:0]};
                    res.cnt     = C_CNT_W'(1);
                end else begin
                    res.data[0] = C_PCT;
                    res.data[1] = r_first;
                    res.data[2] = r_in_byte;
                    res.cnt     = C_CNT_W'(3);
                end
                n_phase = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
                if (r_in_byte == C_PCT) begin
                    if (r_in_last) begin
                        res.data[0] = C_PCT;
                        res.cnt     = C_CNT_W'(1);
                    end else begin
                        n_phase     = PH_PCT;
                    end
                end else if (r_in_byte == C_PLUS && r_plus_to_space) begin
                    res.data[0] = C_SPACE;
                    res.cnt     = C_CNT_W'(1);
                end else begin
                    res.data[0] = r_in_byte;
                    res.cnt     = C_CNT_W'(1);
                end
            end
        endcase
        if (r_in_last) begin
            n_phase = PH_IDLE;
        end
        res.last = r_in_last;
    end

endmodule

`default_nettype wire

// File: hdl/upd_serialiser.sv
// ----------------------------------------------------------------------------
// upd_serialiser
// Result register; hands out a result set one beat at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_serialiser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_vld,
    input  upd_pkg::t_res_set i_res,
    output logic              o_free,
    upd_out_if.source         o_out
);
    import upd_pkg::*;

    logic [C_MAX_RES-1:0][7:0] r_data;
    logic [C_CNT_W-1:0]        r_left;
    logic                      r_last;
    logic                      pop;
    logic                      load;

    assign pop    = o_out.valid && o_out.ready;
    assign o_free = (r_left == '0) || (r_left == C_CNT_W'(1) && o_out.ready);
    assign load   = i_res_vld && o_free;

    assign o_out.valid      = (r_left != '0);
    assign o_out.out_byte   = r_data[0];
    assign o_out.run_last   = (r_left == C_CNT_W'(1));
    assign o_out.string_end = (r_left == C_CNT_W'(1)) && r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (load) begin
            r_left <= i_res.cnt;
        end else if (pop) begin
            r_left <= r_left - C_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= i_res.data;
            r_last <= i_res.last;
        end else if (pop) begin
            r_data <= {8'h00, r_data[C_MAX_RES-1:1]};
        end
    end

endmodule

`default_nettype wire

// File: hdl/url_percent_decoder.sv
// ----------------------------------------------------------------------------
// url_percent_decoder
// Percent-escape decoder for a byte stream, optional '+' to space.
// ----------------------------------------------------------------------------
//  channel   dir  fields                          beat when
//  i_in      in   in_byte, in_last                valid && ready
//  o_out     out  out_byte, run_last, string_end  valid && ready
//  i_cfg_*   in   plus-to-space flag              i_cfg_wr_en
//
//  One input beat a cycle while the output takes results; an item giving n
//  results holds the input until all n are taken, worst for a bad escape.
//  Path: input register, then decode into the result register.
//  Reset is synchronous; clears phase, register and valid state.
//  Output stalls reach the input through the result register's free flag.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module url_percent_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_wr_en,
    input  logic      i_cfg_wr_data,
    upd_in_if.sink    i_in,
    upd_out_if.source o_out
);
    import upd_pkg::*;

    logic     res_vld;
    logic     free;
    t_res_set res;

    upd_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (i_in),
        .i_free        (free),
        .o_res_vld     (res_vld),
        .o_res         (res)
    );

    upd_serialiser u_ser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_res_vld (res_vld),
        .i_res     (res),
        .o_free    (free),
        .o_out     (o_out)
    );

    `ASSERT_CLK(a_end_yields, i_clk, i_rst_n,
        (res_vld && res.last) |-> (res.cnt != '0),
        "end of string gives no result")
    `ASSERT_CLK(a_push_shows, i_clk, i_rst_n,
        (res_vld && free) |=> (o_out.valid == ($past(res.cnt) != '0)),
        "result set not presented")
    `ASSERT_CLK(a_end_is_run_last, i_clk, i_rst_n,
        (o_out.valid && o_out.string_end) |-> o_out.run_last,
        "string end off run end")

endmodule

`default_nettype wire
